### sv/atq_pkg.sv
// Package for the allocation tracker with quarantine.
// Holds the sequencer states, request, result and slot codes, the record layout and
// the hash multiplier. It depends on nothing.
package atq_pkg;

    // Golden-ratio multiplier of the slot hash.
    localparam logic [63:0] HASH_MUL = 64'h9E3779B97F4A7C15;

    // Configuration register indexes.
    localparam logic CFG_CAPACITY  = 1'b0;
    localparam logic CFG_MANDATORY = 1'b1;

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_QUERY = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        K_RECORDED    = 3'd0,
        K_QUARANTINED = 3'd1,
        K_RELEASE     = 3'd2,
        K_DOUBLE_FREE = 3'd3,
        K_UNKNOWN     = 3'd4,
        K_TABLE_FULL  = 3'd5,
        K_QUERY_HIT   = 3'd6,
        K_QUERY_MISS  = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        ST_EMPTY = 2'd0,
        ST_OCC   = 2'd1,
        ST_TOMB  = 2'd2
    } t_slot;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_MOD,
        S_INS,
        S_LRD,
        S_LCHK,
        S_ECHK,
        S_ERING,
        S_EMEM
    } t_state;

    // One table record as stored in the record memory.
    typedef struct packed {
        logic        inq;
        logic [31:0] size;
        logic [47:0] raw;
        logic [47:0] key;
    } t_rec;

endpackage

### sv/allocation_tracker_with_quarantine_unit.sv
// Top level of the allocation tracker with quarantine.
// Uses atq_pkg for codes, states and the record layout; instantiates nothing.
//
// Channel    | Ports                                           | Transfer
// request    | i_req_type, i_addr, i_raw_addr, i_size          | start high while busy low
// result     | o_kind, o_raw_out, o_size_out, o_freed_flag,    | o_valid high, one cycle
//            | o_violation, o_last                             |
// config     | i_cfg_we, i_cfg_idx, i_cfg_data                 | i_cfg_we high
//
// The hash takes 3 multiply steps (64 by 16 bits each) and 16 modulo steps of 4 bits.
// An alloc is then busy one cycle per probed slot.
// A free or query reads the record memory on each probe; each quarantine eviction reads
// the ring and then the record, and parking writes the record. Each result shows in the cycle after.
// Synchronous active-low reset empties the table and the quarantine at once.
// The receiver cannot stall; each result stands on the ports for one cycle.
module allocation_tracker_with_quarantine_unit
    import atq_pkg::*;
#(
    parameter int RECORDS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [47:0] i_addr,
    input  logic [47:0] i_raw_addr,
    input  logic [31:0] i_size,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    output logic [2:0]  o_kind,
    output logic [47:0] o_raw_out,
    output logic [31:0] o_size_out,
    output logic        o_freed_flag,
    output logic        o_violation,
    output logic        o_last
);

    localparam int IW = $clog2(RECORDS);
    localparam int CW = (IW + 1 > 5) ? IW + 1 : 5;
    localparam logic [IW:0]   R_FULL = (IW + 1)'(RECORDS);
    localparam logic [IW-1:0] R_LAST = IW'(RECORDS - 1);
    localparam logic [CW-1:0] C_LAST = CW'(RECORDS - 1);

    // Registers.
    t_state            r_state, n_state;
    t_req              r_req, n_req;
    logic [47:0]       r_addr, n_addr;
    logic [47:0]       r_raw, n_raw;
    logic [31:0]       r_size, n_size;
    logic [63:0]       r_mc, n_mc;
    logic [43:0]       r_k, n_k;
    logic [63:0]       r_acc, n_acc;
    logic [63:0]       r_h, n_h;
    logic [IW-1:0]     r_rem, n_rem;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [IW-1:0]     r_idx, n_idx;
    logic [IW-1:0]     r_tomb, n_tomb;
    logic              r_tomb_v, n_tomb_v;
    t_rec              r_rec, n_rec;
    t_slot             r_status [RECORDS];
    t_slot             n_status [RECORDS];
    logic [IW-1:0]     r_head, n_head;
    logic [IW-1:0]     r_tail, n_tail;
    logic [IW:0]       r_count, n_count;
    logic [31:0]       r_qb, n_qb;
    logic [31:0]       r_cap;
    logic              r_mode;

    // Record and ring memories.
    t_rec              r_mem [RECORDS];
    t_rec              r_rdata;
    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    logic [IW-1:0]     mem_raddr;
    t_rec              mem_wdata;
    logic [IW-1:0]     r_ring [RECORDS];
    logic [IW-1:0]     r_ring_q;
    logic              ring_we;

    // Result register.
    logic              r_o_valid;
    t_kind             r_o_kind;
    logic [47:0]       r_o_raw;
    logic [31:0]       r_o_size;
    logic              r_o_freed;
    logic              r_o_viol;
    logic              r_o_last;

    // Emission request from the sequencer.
    logic              e_valid;
    t_kind             e_kind;
    logic [47:0]       e_raw;
    logic [31:0]       e_size;
    logic              e_freed;
    logic              e_viol;
    logic              e_last;

    // Helpers.
    logic [79:0]       prod;
    logic [63:0]       acc_sum;
    logic [IW:0]       rem_w [5];
    logic [IW-1:0]     rem_next;
    t_slot             cur_st;
    logic [IW-1:0]     idx_inc;
    logic [IW-1:0]     head_inc;
    logic [IW-1:0]     tail_inc;
    logic              do_ins;
    logic [IW-1:0]     pick;
    logic              lk_hit;
    logic              ev_need;

    assign busy = (r_state != S_IDLE);

    // One multiply step of the hash: constant times a 16-bit slice of the key.
    assign prod    = {16'b0, r_mc} * {64'b0, r_k[15:0]};
    assign acc_sum = r_acc + prod[63:0];

    // Four bits of the modulo reduction per cycle, most significant first.
    always_comb begin
        rem_w[0] = {1'b0, r_rem};
        for (int b = 0; b < 4; b++) begin
            rem_w[b+1] = {rem_w[b][IW-1:0], r_h[63-b]};
            if (rem_w[b+1] >= R_FULL) begin
                rem_w[b+1] = rem_w[b+1] - R_FULL;
            end
        end
        rem_next = rem_w[4][IW-1:0];
    end

    assign cur_st   = r_status[r_idx];
    assign idx_inc  = (r_idx == R_LAST) ? '0 : r_idx + 1'b1;
    assign head_inc = (r_head == R_LAST) ? '0 : r_head + 1'b1;
    assign tail_inc = (r_tail == R_LAST) ? '0 : r_tail + 1'b1;
    assign lk_hit   = (cur_st == ST_OCC) && (r_rdata.key == r_addr);
    assign ev_need  = (r_count != '0) &&
                      (({1'b0, r_qb} + {1'b0, r_rec.size} > {1'b0, r_cap}) ||
                       (r_count == R_FULL));

    // Sequencer: next state, datapath updates and result emission.
    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_addr   = r_addr;
        n_raw    = r_raw;
        n_size   = r_size;
        n_mc     = r_mc;
        n_k      = r_k;
        n_acc    = r_acc;
        n_h      = r_h;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_tomb   = r_tomb;
        n_tomb_v = r_tomb_v;
        n_rec    = r_rec;
        n_status = r_status;
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_qb     = r_qb;
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_raddr = r_idx;
        mem_wdata = '{inq: 1'b0, size: r_size, raw: r_raw, key: r_addr};
        ring_we   = 1'b0;
        e_valid  = 1'b0;
        e_kind   = K_RECORDED;
        e_raw    = '0;
        e_size   = '0;
        e_freed  = 1'b0;
        e_viol   = 1'b0;
        e_last   = 1'b1;
        do_ins   = 1'b0;
        pick     = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req  = t_req'(i_req_type);
                    n_addr = i_addr;
                    n_raw  = i_raw_addr;
                    n_size = i_size;
                    n_mc   = HASH_MUL;
                    n_k    = i_addr[47:4];
                    n_acc  = '0;
                    n_cnt  = '0;
                    case (i_req_type)
                        REQ_ALLOC: if (i_size != '0) n_state = S_MUL;
                        REQ_FREE:  if (i_addr != '0) n_state = S_MUL;
                        REQ_QUERY: n_state = S_MUL;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_MUL: begin
                n_acc = acc_sum;
                n_mc  = r_mc << 16;
                n_k   = r_k >> 16;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(2)) begin
                    n_h     = acc_sum;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                n_rem = rem_next;
                n_h   = r_h << 4;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(15)) begin
                    n_idx    = rem_next;
                    n_cnt    = '0;
                    n_tomb_v = 1'b0;
                    if (r_req == REQ_ALLOC) begin
                        n_state = S_INS;
                    end else if (r_addr == '0) begin
                        // Query of the null pointer never hits.
                        e_valid = 1'b1;
                        e_kind  = K_QUERY_MISS;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_LRD;
                    end
                end
            end
            S_INS: begin
                // Insert probe: first empty slot ends the walk, first tombstone is kept.
                if (cur_st == ST_EMPTY) begin
                    do_ins = 1'b1;
                    pick   = r_tomb_v ? r_tomb : r_idx;
                end else begin
                    if (!r_tomb_v && cur_st == ST_TOMB) begin
                        n_tomb   = r_idx;
                        n_tomb_v = 1'b1;
                    end
                    if (r_cnt == C_LAST) begin
                        if (r_tomb_v || cur_st == ST_TOMB) begin
                            do_ins = 1'b1;
                            pick   = r_tomb_v ? r_tomb : r_idx;
                        end else begin
                            e_valid = 1'b1;
                            e_kind  = K_TABLE_FULL;
                            e_raw   = r_raw;
                            e_size  = r_size;
                            e_viol  = r_mode;
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_idx = idx_inc;
                        n_cnt = r_cnt + 1'b1;
                    end
                end
                if (do_ins) begin
                    n_status[pick] = ST_OCC;
                    mem_we    = 1'b1;
                    mem_waddr = pick;
                    e_valid   = 1'b1;
                    e_kind    = K_RECORDED;
                    e_raw     = r_raw;
                    e_size    = r_size;
                    n_state   = S_IDLE;
                end
            end
            S_LRD: begin
                mem_raddr = r_idx;
                n_state   = S_LCHK;
            end
            S_LCHK: begin
                if (lk_hit) begin
                    n_rec = r_rdata;
                    if (r_req == REQ_QUERY) begin
                        e_valid = 1'b1;
                        e_kind  = K_QUERY_HIT;
                        e_raw   = r_rdata.raw;
                        e_size  = r_rdata.size;
                        e_freed = r_rdata.inq;
                        n_state = S_IDLE;
                    end else if (r_rdata.inq) begin
                        e_valid = 1'b1;
                        e_kind  = K_DOUBLE_FREE;
                        e_raw   = r_rdata.raw;
                        e_size  = r_rdata.size;
                        e_viol  = 1'b1;
                        n_state = S_IDLE;
                    end else if (r_cap != '0 && r_rdata.size <= r_cap) begin
                        n_state = S_ECHK;
                    end else begin
                        // Immediate release of the block.
                        n_status[r_idx] = ST_TOMB;
                        e_valid = 1'b1;
                        e_kind  = K_RELEASE;
                        e_raw   = r_rdata.raw;
                        e_size  = r_rdata.size;
                        n_state = S_IDLE;
                    end
                end else if (cur_st == ST_EMPTY || r_cnt == C_LAST) begin
                    e_valid = 1'b1;
                    if (r_req == REQ_QUERY) begin
                        e_kind = K_QUERY_MISS;
                    end else begin
                        e_kind = K_UNKNOWN;
                        e_viol = 1'b1;
                    end
                    n_state = S_IDLE;
                end else begin
                    n_idx   = idx_inc;
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_LRD;
                end
            end
            S_ECHK: begin
                if (ev_need) begin
                    n_state = S_ERING;
                end else begin
                    // Park the record at the ring tail.
                    mem_we    = 1'b1;
                    mem_waddr = r_idx;
                    mem_wdata = '{inq: 1'b1, size: r_rec.size, raw: r_rec.raw, key: r_rec.key};
                    ring_we   = 1'b1;
                    n_tail    = tail_inc;
                    n_count   = r_count + 1'b1;
                    n_qb      = r_qb + r_rec.size;
                    e_valid   = 1'b1;
                    e_kind    = K_QUARANTINED;
                    e_raw     = r_rec.raw;
                    e_size    = r_rec.size;
                    n_state   = S_IDLE;
                end
            end
            S_ERING: begin
                mem_raddr = r_ring_q;
                n_state   = S_EMEM;
            end
            S_EMEM: begin
                // Evict the oldest quarantined record.
                n_status[r_ring_q] = ST_TOMB;
                n_head  = head_inc;
                n_count = r_count - 1'b1;
                n_qb    = (r_qb >= r_rdata.size) ? r_qb - r_rdata.size : '0;
                e_valid = 1'b1;
                e_kind  = K_RELEASE;
                e_raw   = r_rdata.raw;
                e_size  = r_rdata.size;
                e_last  = 1'b0;
                n_state = S_ECHK;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_qb      <= '0;
            r_o_valid <= 1'b0;
            for (int i = 0; i < RECORDS; i++) begin
                r_status[i] <= ST_EMPTY;
            end
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_qb      <= n_qb;
            r_o_valid <= e_valid;
            r_status  <= n_status;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= '0;
            r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_CAPACITY) begin
                r_cap <= i_cfg_data;
            end
            if (i_cfg_idx == CFG_MANDATORY) begin
                r_mode <= i_cfg_data[0];
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_addr   <= n_addr;
        r_raw    <= n_raw;
        r_size   <= n_size;
        r_mc     <= n_mc;
        r_k      <= n_k;
        r_acc    <= n_acc;
        r_h      <= n_h;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_idx    <= n_idx;
        r_tomb   <= n_tomb;
        r_tomb_v <= n_tomb_v;
        r_rec    <= n_rec;
    end

    // Record memory with registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    // Quarantine ring: written at the tail, read at the head.
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[r_tail] <= r_idx;
        end
        r_ring_q <= r_ring[r_head];
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        r_o_kind  <= e_kind;
        r_o_raw   <= e_raw;
        r_o_size  <= e_size;
        r_o_freed <= e_freed;
        r_o_viol  <= e_viol;
        r_o_last  <= e_last;
    end

    assign o_valid      = r_o_valid;
    assign o_kind       = r_o_kind;
    assign o_raw_out    = r_o_raw;
    assign o_size_out   = r_o_size;
    assign o_freed_flag = r_o_freed;
    assign o_violation  = r_o_viol;
    assign o_last       = r_o_last;

endmodule

### test/tb_allocation_tracker_with_quarantine_unit.sv
// Testbench for the allocation tracker with quarantine.
// Drives requests and register writes, predicts every result with its own table model,
// and checks the results in order. Depends on atq_pkg and the unit's RTL.
module tb_allocation_tracker_with_quarantine_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import atq_pkg::*;

    localparam int SLOTS = 32;

    // One result of the tracker.
    typedef struct packed {
        logic [2:0]  kind;
        logic [47:0] raw;
        logic [31:0] size;
        logic        freed;
        logic        viol;
        logic        last;
    } t_event;

    // Mirror of the tracker state and the expected results, checked in order.
    class tracker_board;
        t_slot        status [SLOTS];
        logic [47:0]  key [SLOTS];
        logic [47:0]  raw [SLOTS];
        logic [31:0]  size [SLOTS];
        logic         inq [SLOTS];
        int           ring [SLOTS];
        int           head, tail, count;
        logic [31:0]  held_bytes;
        logic [31:0]  capacity;
        logic         mandatory;
        t_event       pending [$];
        int           mismatches;

        function void clear();
            foreach (status[i]) begin
                status[i] = ST_EMPTY;
                inq[i] = 1'b0;
            end
            head = 0;
            tail = 0;
            count = 0;
            held_bytes = '0;
            capacity = '0;
            mandatory = 1'b0;
            mismatches = 0;
        endfunction

        function int home(logic [47:0] a);
            logic [63:0] h;
            h = {20'd0, a[47:4]} * HASH_MUL;
            return int'(h[4:0]);
        endfunction

        function int find(logic [47:0] a);
            int idx;
            idx = home(a);
            if (a == '0) return SLOTS;
            for (int n = 0; n < SLOTS; n++) begin
                if (status[idx] == ST_EMPTY) return SLOTS;
                if (status[idx] == ST_OCC && key[idx] == a) return idx;
                idx = (idx + 1) % SLOTS;
            end
            return SLOTS;
        endfunction

        function int claim(logic [47:0] a);
            int idx, tomb, pick;
            idx = home(a);
            tomb = SLOTS;
            pick = SLOTS;
            for (int n = 0; n < SLOTS; n++) begin
                if (status[idx] == ST_EMPTY) begin
                    pick = (tomb != SLOTS) ? tomb : idx;
                    break;
                end
                if (status[idx] == ST_TOMB && tomb == SLOTS) tomb = idx;
                idx = (idx + 1) % SLOTS;
            end
            if (pick == SLOTS) pick = tomb;
            if (pick != SLOTS) begin
                status[pick] = ST_OCC;
                key[pick] = a;
            end
            return pick;
        endfunction

        function void push(t_kind k, logic [47:0] r, logic [31:0] s, logic f, logic v);
            t_event e;
            e = '{kind: k, raw: r, size: s, freed: f, viol: v, last: 1'b0};
            pending.push_back(e);
        endfunction

        function void drop(int s);
            status[s] = ST_TOMB;
            key[s] = '0;
            raw[s] = '0;
            inq[s] = 1'b0;
        endfunction

        // Notes an accepted request and queues the results it causes.
        function void note_request(t_req rq, logic [47:0] a, logic [47:0] r, logic [31:0] sz);
            int s, v, prior;
            logic [31:0] vs;
            prior = pending.size();
            if (rq == REQ_ALLOC) begin
                if (sz == '0) return;
                s = claim(a);
                if (s == SLOTS) push(K_TABLE_FULL, r, sz, 1'b0, mandatory);
                else begin
                    raw[s] = r;
                    size[s] = sz;
                    inq[s] = 1'b0;
                    push(K_RECORDED, r, sz, 1'b0, 1'b0);
                end
            end else if (rq == REQ_FREE) begin
                if (a == '0) return;
                s = find(a);
                if (s == SLOTS) push(K_UNKNOWN, '0, '0, 1'b0, 1'b1);
                else if (inq[s]) push(K_DOUBLE_FREE, raw[s], size[s], 1'b0, 1'b1);
                else if (capacity != '0 && size[s] <= capacity) begin
                    while (count > 0 && ({1'b0, held_bytes} + size[s] > {1'b0, capacity}
                           || count >= SLOTS)) begin
                        v = ring[head];
                        vs = size[v];
                        head = (head + 1) % SLOTS;
                        count--;
                        held_bytes = (held_bytes >= vs) ? held_bytes - vs : '0;
                        push(K_RELEASE, raw[v], vs, 1'b0, 1'b0);
                        drop(v);
                    end
                    inq[s] = 1'b1;
                    ring[tail] = s;
                    tail = (tail + 1) % SLOTS;
                    count++;
                    held_bytes = held_bytes + size[s];
                    push(K_QUARANTINED, raw[s], size[s], 1'b0, 1'b0);
                end else begin
                    push(K_RELEASE, raw[s], size[s], 1'b0, 1'b0);
                    drop(s);
                end
            end else if (rq == REQ_QUERY) begin
                s = find(a);
                if (s == SLOTS) push(K_QUERY_MISS, '0, '0, 1'b0, 1'b0);
                else push(K_QUERY_HIT, raw[s], size[s], inq[s], 1'b0);
            end else return;
            if (pending.size() > prior) pending[pending.size() - 1].last = 1'b1;
        endfunction

        // Compares one result with the oldest expectation.
        function void check_result(t_event got);
            t_event want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_req_type;
    logic [47:0] i_addr;
    logic [47:0] i_raw_addr;
    logic [31:0] i_size;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        o_valid;
    logic [2:0]  o_kind;
    logic [47:0] o_raw_out;
    logic [31:0] o_size_out;
    logic        o_freed_flag;
    logic        o_violation;
    logic        o_last;

    tracker_board board;
    logic [47:0]  live_addrs [$];
    bit           calm;

    allocation_tracker_with_quarantine_unit dut (.*);

    // Clock with a 10 ns period.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Every result stands for one cycle and is taken at the edge that ends it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            board.check_result('{kind: o_kind, raw: o_raw_out, size: o_size_out,
                                 freed: o_freed_flag, viol: o_violation, last: o_last});
    end

    // Hard limit on the run time.
    initial begin
        #20ms;
        $display("allocation_tracker_with_quarantine_unit test failed");
        $finish;
    end

    // Offers one request and holds it until the transfer.
    task automatic send(t_req rq, logic [47:0] a, logic [47:0] r, logic [31:0] sz);
        start <= 1'b1;
        i_req_type <= rq;
        i_addr <= a;
        i_raw_addr <= r;
        i_size <= sz;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_request(rq, a, r, sz);
        if (rq == REQ_ALLOC && sz != '0) live_addrs.push_back(a);
        if (!calm && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    // Waits for every expected result, then for the tail of the last job.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0 || busy) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    // One register write; the enable drops again before the next write.
    task automatic write_reg(logic idx, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_CAPACITY) board.capacity = data;
        else board.mandatory = data[0];
    endtask

    function automatic logic [47:0] pick_addr();
        logic [47:0] a;
        if (live_addrs.size() != 0 && $urandom_range(0, 3) != 0)
            return live_addrs[$urandom_range(0, live_addrs.size() - 1)];
        a = 48'({$urandom, $urandom});
        // Many keys near one another collide in the hash.
        if ($urandom_range(0, 1)) a = {36'd0, 8'($urandom), 4'd0};
        return a;
    endfunction

    task automatic random_phase(int items);
        int n;
        logic [1:0] rq;
        logic [31:0] sz;
        n = 0;
        while (n < items) begin
            rq = 2'($urandom_range(0, 9) < 4 ? 0 : $urandom_range(1, 3));
            sz = ($urandom_range(0, 7) == 0) ? $urandom : 32'($urandom_range(1, 300));
            if ($urandom_range(0, 40) == 0) sz = '0;
            send(t_req'(rq), pick_addr(), 48'({$urandom, $urandom}), sz);
            if (rq != 2'd3) n++;
        end
    endtask

    initial begin
        board = new();
        board.clear();
        calm = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req_type = '0;
        i_addr = '0;
        i_raw_addr = '0;
        i_size = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = 1'b0;
        i_cfg_data = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: immediate release, special cases and field extremes.
        send(REQ_ALLOC, 48'h0000_0000_0010, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send(REQ_ALLOC, 48'hFFFF_FFFF_FFFF, 48'h0, 32'd1);
        send(REQ_ALLOC, 48'h0000_0000_0100, 48'h1234, 32'd0);
        send(REQ_QUERY, 48'h0000_0000_0010, '0, '0);
        send(REQ_QUERY, 48'h0, '0, '0);
        send(REQ_FREE, 48'h0, '0, '0);
        send(REQ_FREE, 48'h0000_0000_0777, '0, '0);
        send(t_req'(2'd3), 48'h10, 48'h10, 32'd5);
        send(REQ_FREE, 48'hFFFF_FFFF_FFFF, '0, '0);
        send(REQ_FREE, 48'hFFFF_FFFF_FFFF, '0, '0);
        drain();

        // Quarantine with a small budget: eviction and double free.
        write_reg(CFG_CAPACITY, 32'd100);
        write_reg(CFG_MANDATORY, 32'd1);
        for (int i = 1; i <= 4; i++) send(REQ_ALLOC, 48'(i * 16), 48'(i * 4096), 32'd40);
        send(REQ_FREE, 48'd16, '0, '0);
        send(REQ_FREE, 48'd32, '0, '0);
        send(REQ_QUERY, 48'd16, '0, '0);
        send(REQ_FREE, 48'd16, '0, '0);
        send(REQ_FREE, 48'd48, '0, '0);
        send(REQ_FREE, 48'd0, '0, '0);
        drain();

        // Fill the table to force table-full in mandatory mode.
        for (int i = 0; i < SLOTS + 2; i++)
            send(REQ_ALLOC, 48'(32'h1000 + i * 16), 48'(i), 32'd8);
        drain();
        write_reg(CFG_MANDATORY, 32'd0);
        send(REQ_ALLOC, 48'h9_0000, 48'h5, 32'd3);
        drain();

        // Random phases over several settings, maximum budget included.
        write_reg(CFG_CAPACITY, 32'hFFFF_FFFF);
        random_phase(10);
        drain();
        write_reg(CFG_CAPACITY, 32'd500);
        write_reg(CFG_MANDATORY, 32'd1);
        random_phase(10);
        drain();
        write_reg(CFG_CAPACITY, 32'd0);
        random_phase(10);
        drain();
        write_reg(CFG_CAPACITY, 32'd120);
        write_reg(CFG_MANDATORY, 32'd0);
        calm = 1'b1;
        random_phase(10);
        drain();

        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("allocation_tracker_with_quarantine_unit test passed");
        else
            $display("allocation_tracker_with_quarantine_unit test failed");
        $finish;
    end
endmodule
